>>> sv/psd_pkg.sv
// Shared types and constants for the point to segment distance unit.
// No dependencies.
`timescale 1ns / 1ps

package psd_pkg;

	typedef logic signed [15:0] coord_t;
	typedef logic [24:0]        dist_t;
	typedef logic [1:0]         part_t;

	// Nearest feature codes
	localparam part_t PART_INTERIOR = 2'd0;
	localparam part_t PART_START    = 2'd1;
	localparam part_t PART_END      = 2'd2;

	// Division: 82-bit dividend, 34-bit divisor, 50-bit quotient
	localparam int NUM_W      = 82;
	localparam int DEN_W      = 34;
	localparam int DIV_STEPS  = 50;
	// Square root: 50-bit radicand, 25-bit root
	localparam int SQRT_STEPS = 25;
	localparam int SREM_W     = 27;

endpackage

>>> sv/psd_query_if.sv
// Query channel: a point and a segment, valid/ready handshake.
// Depends on psd_pkg.
`timescale 1ns / 1ps

interface psd_query_if import psd_pkg::*; ();
	logic   valid;
	logic   ready;
	coord_t point_x;
	coord_t point_y;
	coord_t start_x;
	coord_t start_y;
	coord_t end_x;
	coord_t end_y;

	modport source (output valid, point_x, point_y, start_x, start_y, end_x, end_y,
		input ready);
	modport sink (input valid, point_x, point_y, start_x, start_y, end_x, end_y,
		output ready);
endinterface

>>> sv/psd_result_if.sv
// Result channel: distance and nearest feature, valid/ready handshake.
// Depends on psd_pkg.
`timescale 1ns / 1ps

interface psd_result_if import psd_pkg::*; ();
	logic  valid;
	logic  ready;
	dist_t distance;
	part_t nearest_part;

	modport source (output valid, distance, nearest_part, input ready);
	modport sink (input valid, distance, nearest_part, output ready);
endinterface

>>> sv/point_segment_distance_2d_unit.sv
// Fully pipelined point to segment distance, Q17.8 truncated result.
// Depends on psd_pkg, psd_query_if and psd_result_if.
`timescale 1ns / 1ps

// One transaction is accepted every clock cycle while the result side keeps
// up; each result passes through 4 setup stages, a 50-stage restoring divider
// retiring one quotient bit per stage, and a 25-stage square root retiring one
// root bit per stage, the last stage being the output register. The whole
// pipeline advances together on one enable: while a result waits unclaimed
// every stage holds, empty slots included, and query.ready stays low for as
// long as the result waits.
module point_segment_distance_2d_unit import psd_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	psd_query_if.sink         query,
	psd_result_if.source      result
);

	logic en;

	// Stage 1: coordinate differences
	logic                v_s1;
	logic signed [16:0]  dx_s1, dy_s1, ex_s1, ey_s1, fx_s1, fy_s1;
	// Stage 2: products
	logic                v_s2;
	logic signed [33:0]  pdot_x_s2, pdot_y_s2, plen_x_s2, plen_y_s2;
	logic signed [33:0]  pcr_a_s2, pcr_b_s2, pe_x_s2, pe_y_s2, pf_x_s2, pf_y_s2;
	// Stage 3: sums and classification inputs
	logic                v_s3;
	logic signed [35:0]  dot_s3, len2_s3;
	logic [31:0]         cabs_s3;
	logic [33:0]         esum_s3, fsum_s3;
	// Stage 4: dividend and divisor
	logic                v_s4;
	logic [NUM_W-1:0]    num_s4;
	logic [DEN_W-1:0]    den_s4;
	part_t               part_s4;

	// Global advance: pipeline moves unless a finished result is blocked
	assign en          = !result.valid || result.ready;
	assign query.ready = en;

	// Stage 1
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else if (en) v_s1 <= query.valid;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			dx_s1 <= 17'(query.end_x)   - 17'(query.start_x);
			dy_s1 <= 17'(query.end_y)   - 17'(query.start_y);
			ex_s1 <= 17'(query.point_x) - 17'(query.start_x);
			ey_s1 <= 17'(query.point_y) - 17'(query.start_y);
			fx_s1 <= 17'(query.point_x) - 17'(query.end_x);
			fy_s1 <= 17'(query.point_y) - 17'(query.end_y);
		end
	end

	// Stage 2: 17x17 products in parallel
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s2 <= 1'b0;
		else if (en) v_s2 <= v_s1;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			pdot_x_s2 <= 34'(ex_s1) * 34'(dx_s1);
			pdot_y_s2 <= 34'(ey_s1) * 34'(dy_s1);
			plen_x_s2 <= 34'(dx_s1) * 34'(dx_s1);
			plen_y_s2 <= 34'(dy_s1) * 34'(dy_s1);
			pcr_a_s2  <= 34'(dx_s1) * 34'(ey_s1);
			pcr_b_s2  <= 34'(dy_s1) * 34'(ex_s1);
			pe_x_s2   <= 34'(ex_s1) * 34'(ex_s1);
			pe_y_s2   <= 34'(ey_s1) * 34'(ey_s1);
			pf_x_s2   <= 34'(fx_s1) * 34'(fx_s1);
			pf_y_s2   <= 34'(fy_s1) * 34'(fy_s1);
		end
	end

	// Stage 3: dot, squared length, |cross|, squared endpoint distances
	logic signed [35:0] cross_c;
	assign cross_c = 36'(pcr_a_s2) - 36'(pcr_b_s2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s3 <= 1'b0;
		else if (en) v_s3 <= v_s2;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			dot_s3  <= 36'(pdot_x_s2) + 36'(pdot_y_s2);
			len2_s3 <= 36'(plen_x_s2) + 36'(plen_y_s2);
			// |cross| is at most twice the largest triangle area, below 2^32
			cabs_s3 <= cross_c[35] ? 32'(-cross_c) : 32'(cross_c);
			esum_s3 <= 34'(pe_x_s2) + 34'(pe_y_s2);
			fsum_s3 <= 34'(pf_x_s2) + 34'(pf_y_s2);
		end
	end

	// Stage 4: pick the case, square the cross product
	logic interior_c, start_c;
	assign interior_c = (dot_s3 > 36'sd0) && (dot_s3 < len2_s3);
	assign start_c    = (dot_s3 <= 36'sd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s4 <= 1'b0;
		else if (en) v_s4 <= v_s3;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			if (interior_c) begin
				num_s4  <= {18'(0), 64'(cabs_s3) * 64'(cabs_s3)} << 16;
				den_s4  <= len2_s3[DEN_W-1:0];
				part_s4 <= PART_INTERIOR;
			end else if (start_c) begin
				num_s4  <= NUM_W'({esum_s3, 16'd0});
				den_s4  <= DEN_W'(1);
				part_s4 <= PART_START;
			end else begin
				num_s4  <= NUM_W'({fsum_s3, 16'd0});
				den_s4  <= DEN_W'(1);
				part_s4 <= PART_END;
			end
		end
	end

	// Divider: one restoring step per stage; quotient bits shift in behind
	// the dividend bits they replace
	logic                v_div  [0:DIV_STEPS];
	logic [DEN_W-1:0]    rem_div[0:DIV_STEPS];
	logic [DIV_STEPS-1:0] qn_div[0:DIV_STEPS];
	logic [DEN_W-1:0]    den_div[0:DIV_STEPS];
	part_t               prt_div[0:DIV_STEPS];

	assign v_div[0]   = v_s4;
	assign rem_div[0] = DEN_W'(num_s4[NUM_W-1:DIV_STEPS]);
	assign qn_div[0]  = num_s4[DIV_STEPS-1:0];
	assign den_div[0] = den_s4;
	assign prt_div[0] = part_s4;

	for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
		logic [DEN_W:0] trial;
		logic [DEN_W:0] diff;
		logic           ge;
		assign trial = {rem_div[k], qn_div[k][DIV_STEPS-1]};
		assign diff  = trial - {1'b0, den_div[k]};
		assign ge    = trial >= {1'b0, den_div[k]};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) v_div[k+1] <= 1'b0;
			else if (en) v_div[k+1] <= v_div[k];
		end
		always_ff @(posedge clk) begin
			if (en) begin
				rem_div[k+1] <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
				qn_div[k+1]  <= {qn_div[k][DIV_STEPS-2:0], ge};
				den_div[k+1] <= den_div[k];
				prt_div[k+1] <= prt_div[k];
			end
		end
	end

	// Square root: one root bit per stage
	logic                  v_sq   [0:SQRT_STEPS];
	logic [SREM_W-1:0]     rem_sq [0:SQRT_STEPS];
	logic [SQRT_STEPS-1:0] root_sq[0:SQRT_STEPS];
	logic [DIV_STEPS-1:0]  x_sq   [0:SQRT_STEPS];
	part_t                 prt_sq [0:SQRT_STEPS];

	assign v_sq[0]    = v_div[DIV_STEPS];
	assign rem_sq[0]  = '0;
	assign root_sq[0] = '0;
	assign x_sq[0]    = qn_div[DIV_STEPS];
	assign prt_sq[0]  = prt_div[DIV_STEPS];

	for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
		logic [SREM_W:0] r2;
		logic [SREM_W:0] trial;
		logic            ge;
		assign r2    = {rem_sq[k][SREM_W-2:0], x_sq[k][DIV_STEPS-1 -: 2]};
		assign trial = (SREM_W+1)'({root_sq[k], 2'b01});
		assign ge    = r2 >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) v_sq[k+1] <= 1'b0;
			else if (en) v_sq[k+1] <= v_sq[k];
		end
		always_ff @(posedge clk) begin
			if (en) begin
				rem_sq[k+1]  <= ge ? SREM_W'(r2 - trial) : SREM_W'(r2);
				root_sq[k+1] <= {root_sq[k][SQRT_STEPS-2:0], ge};
				x_sq[k+1]    <= {x_sq[k][DIV_STEPS-3:0], 2'b00};
				prt_sq[k+1]  <= prt_sq[k];
			end
		end
	end

	// Output
	assign result.valid        = v_sq[SQRT_STEPS];
	assign result.distance     = root_sq[SQRT_STEPS];
	assign result.nearest_part = prt_sq[SQRT_STEPS];

endmodule
